// File: rtl/tsa_pkg.sv
`default_nettype none
package tsa_pkg;

  localparam int VAL_W = 16;
  localparam int SUM_W = 27;
  localparam int CFG_IDX_W = 1;

  localparam logic [15:0] EV_TYPE_ABS   = 16'd3;
  localparam logic [15:0] CODE_X        = 16'd0;
  localparam logic [15:0] CODE_Y        = 16'd1;
  localparam logic [15:0] CODE_PRESSURE = 16'd24;

  localparam logic [CFG_IDX_W-1:0] CFG_X_DIVISOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_DIVISOR = 1'b1;

  localparam int EMPTY_X_BIT = 0;
  localparam int EMPTY_Y_BIT = 1;
  localparam int EMPTY_P_BIT = 2;

  typedef struct packed {
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [15:0] event_value;
  } tsa_in_t;

  typedef struct packed {
    logic signed [15:0] x_avg;
    logic signed [15:0] y_avg;
    logic signed [15:0] pressure_avg;
    logic [2:0]         axis_empty;
  } tsa_out_t;

endpackage
`default_nettype wire

// File: rtl/tsa_div.sv
`default_nettype none
module tsa_div
  import tsa_pkg::*;
#(
  parameter int DVS_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [SUM_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [STEP_W-1:0]  step_r;
  logic               neg_r;
  logic [DVS_W-1:0]   den_r;
  logic [DVS_W:0]     rem_r;
  logic [SUM_W-1:0]   quo_r;

  logic [DVS_W:0]     rem_sh;
  logic [DVS_W+1:0]   diff;
  logic               fits;
  logic [SUM_W-1:0]   mag;

  // Restoring division on magnitudes: the dividend shifts out of quo_r at the
  // top while quotient bits shift in at the bottom.
  always_comb begin
    rem_sh = {rem_r[DVS_W-1:0], quo_r[SUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
    fits   = ~diff[DVS_W+1];
    mag    = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
        den_r  <= divisor;
        rem_r  <= '0;
        quo_r  <= mag;
        neg_r  <= dividend[SUM_W-1];
      end else if (busy_r) begin
        rem_r  <= fits ? diff[DVS_W:0] : rem_sh;
        quo_r  <= {quo_r[SUM_W-2:0], fits};
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The divisor is always positive, so the quotient takes the dividend's sign.
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

// File: rtl/touch_sample_averager.sv
`default_nettype none
// Touch sample averager. X and Y samples of absolute events are scaled by
// their divisor registers (a divisor of 0 acts as 1) and summed per axis;
// nonzero pressure samples are summed raw. A zero pressure ends the touch and
// delivers one item with the truncated averages of all three axes, a flag for
// each axis that saw no sample, and clears the sums. Each axis stops counting
// at MAX_SAMPLES. All division runs through one shared radix-2 serial
// divider: its 27 shift steps, the load step and the done step hold the
// sequencer for each division. An X or Y event occupies the block until its
// division is done, a touch end until all three divisions have run and the
// result is loaded (longer if the previous result is still stalled), and
// every other event does not hold the block. The input is stalled while an
// event is in progress; a delivered result waits in an output register.
module touch_sample_averager
  import tsa_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tsa_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tsa_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int DVS_W = (CNT_W > VAL_W) ? CNT_W : VAL_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_AVG_X,
    ST_AVG_Y,
    ST_AVG_P,
    ST_EMIT
  } state_t;

  state_t             state_r;
  logic [15:0]        x_div_r;
  logic [15:0]        y_div_r;
  logic [SUM_W-1:0]   x_sum_r;
  logic [SUM_W-1:0]   y_sum_r;
  logic [SUM_W-1:0]   p_sum_r;
  logic [CNT_W-1:0]   x_cnt_r;
  logic [CNT_W-1:0]   y_cnt_r;
  logic [CNT_W-1:0]   p_cnt_r;
  logic               sel_y_r;
  logic [15:0]        x_avg_r;
  logic [15:0]        y_avg_r;
  logic [15:0]        p_avg_r;
  logic [2:0]         empty_r;
  logic               div_go_r;
  logic [SUM_W-1:0]   div_num_r;
  logic [DVS_W-1:0]   div_den_r;
  logic               out_valid_r;
  tsa_out_t           out_data_r;

  logic               div_done;
  logic [SUM_W-1:0]   div_q;
  logic               in_take;
  logic               out_free;
  logic [SUM_W-1:0]   value_ext;
  logic [DVS_W-1:0]   x_den;
  logic [DVS_W-1:0]   y_den;

  function automatic logic [DVS_W-1:0] count_den(input logic [CNT_W-1:0] c);
    // An empty axis has a zero sum, so dividing it by one yields the 0 output.
    count_den = (c == '0) ? DVS_W'(1) : DVS_W'(c);
  endfunction

  tsa_div #(
    .DVS_W(DVS_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_go_r),
    .dividend(div_num_r),
    .divisor (div_den_r),
    .done    (div_done),
    .quotient(div_q)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign value_ext = {{(SUM_W - VAL_W){in_data.event_value[VAL_W-1]}}, in_data.event_value};
  assign x_den     = (x_div_r == '0) ? DVS_W'(1) : DVS_W'(x_div_r);
  assign y_den     = (y_div_r == '0) ? DVS_W'(1) : DVS_W'(y_div_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_div_r <= 16'd1;
      y_div_r <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_DIVISOR: x_div_r <= cfg_data;
        CFG_Y_DIVISOR: y_div_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      x_sum_r     <= '0;
      y_sum_r     <= '0;
      p_sum_r     <= '0;
      x_cnt_r     <= '0;
      y_cnt_r     <= '0;
      p_cnt_r     <= '0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_take && in_data.event_type == EV_TYPE_ABS) begin
            priority if (in_data.event_code == CODE_X) begin
              div_num_r <= value_ext;
              div_den_r <= x_den;
              div_go_r  <= 1'b1;
              sel_y_r   <= 1'b0;
              state_r   <= ST_SAMPLE;
            end else if (in_data.event_code == CODE_Y) begin
              div_num_r <= value_ext;
              div_den_r <= y_den;
              div_go_r  <= 1'b1;
              sel_y_r   <= 1'b1;
              state_r   <= ST_SAMPLE;
            end else if (in_data.event_code == CODE_PRESSURE) begin
              if (in_data.event_value != '0) begin
                if (p_cnt_r < CNT_MAX) begin
                  p_sum_r <= p_sum_r + value_ext;
                  p_cnt_r <= p_cnt_r + 1'b1;
                end
              end else begin
                // Zero pressure: the touch has ended.
                empty_r[EMPTY_X_BIT] <= (x_cnt_r == '0);
                empty_r[EMPTY_Y_BIT] <= (y_cnt_r == '0);
                empty_r[EMPTY_P_BIT] <= (p_cnt_r == '0);
                div_num_r <= x_sum_r;
                div_den_r <= count_den(x_cnt_r);
                div_go_r  <= 1'b1;
                state_r   <= ST_AVG_X;
              end
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_SAMPLE: begin
          if (div_done) begin
            if (sel_y_r) begin
              if (y_cnt_r < CNT_MAX) begin
                y_sum_r <= y_sum_r + div_q;
                y_cnt_r <= y_cnt_r + 1'b1;
              end
            end else if (x_cnt_r < CNT_MAX) begin
              x_sum_r <= x_sum_r + div_q;
              x_cnt_r <= x_cnt_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        ST_AVG_X: begin
          if (div_done) begin
            x_avg_r   <= div_q[15:0];
            div_num_r <= y_sum_r;
            div_den_r <= count_den(y_cnt_r);
            div_go_r  <= 1'b1;
            state_r   <= ST_AVG_Y;
          end
        end
        ST_AVG_Y: begin
          if (div_done) begin
            y_avg_r   <= div_q[15:0];
            div_num_r <= p_sum_r;
            div_den_r <= count_den(p_cnt_r);
            div_go_r  <= 1'b1;
            state_r   <= ST_AVG_P;
          end
        end
        ST_AVG_P: begin
          if (div_done) begin
            p_avg_r <= div_q[15:0];
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data_r.x_avg        <= x_avg_r;
            out_data_r.y_avg        <= y_avg_r;
            out_data_r.pressure_avg <= p_avg_r;
            out_data_r.axis_empty   <= empty_r;
            out_valid_r             <= 1'b1;
            x_sum_r                 <= '0;
            y_sum_r                 <= '0;
            p_sum_r                 <= '0;
            x_cnt_r                 <= '0;
            y_cnt_r                 <= '0;
            p_cnt_r                 <= '0;
            state_r                 <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result item appeared outside the emit step");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=>
      (x_cnt_r == '0 && y_cnt_r == '0 && p_cnt_r == '0 && p_sum_r == '0))
    else $error("sums and counts not cleared after a touch ended");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (x_cnt_r <= CNT_MAX && y_cnt_r <= CNT_MAX && p_cnt_r <= CNT_MAX))
    else $error("sample count exceeded its limit");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r != ST_IDLE && state_r != ST_EMIT))
    else $error("divider finished while no division was pending");

endmodule
`default_nettype wire
